// File: sv/pooled_linked_list_engine_defines.svh
// assertion macros for the pooled linked list engine
// used by the top level only, needs a clk and an arst_n in scope
`ifndef POOLED_LINKED_LIST_ENGINE_DEFINES_SVH
`define POOLED_LINKED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define PLLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PLLE_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PLLE_ASSERT(lbl, prop, msg)
`define PLLE_NEVER(lbl, expr, msg)
`endif
`endif

// File: sv/plle_pkg.sv
// shared widths, opcodes and status codes of the pooled linked list engine
// no dependencies
package plle_pkg;
	localparam int POOL_SLOTS_DEF = 128;
	localparam int OP_W = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W = 7;
	localparam int SLOT_W = 7;
	localparam int LEN_W = 8;
	localparam int STATUS_W = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;
endpackage

// File: sv/plle_ram.sv
// generic one write, one read port ram with registered read data
// no dependencies
module plle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/pooled_linked_list_engine.sv
// pooled linked list engine: sequencer over a value ram and a link/used ram
// depends on plle_pkg, plle_ram and pooled_linked_list_engine_defines.svh
// one word at a time; append scans the link ram for a free slot among the hw slots ever used
// (one slot a cycle), else takes slot hw, or answers full; delete/read at position p walk
// from the head one link a cycle; an error or unused op goes straight to its result; each
// result shows in the cycle the next word can be taken; reset empties the list, no ram sweep
`include "pooled_linked_list_engine_defines.svh"
module pooled_linked_list_engine #(
	parameter int POOL_SLOTS = plle_pkg::POOL_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [plle_pkg::S_TDATA_W-1:0] s_tdata,  // value, position, zero pad
	input  logic [plle_pkg::OP_W-1:0]      s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [plle_pkg::M_TDATA_W-1:0] m_tdata,  // slot, read_value, length, zero pad
	output logic [plle_pkg::STATUS_W-1:0]  m_tuser   // status
);
	import plle_pkg::*;

	localparam int SW  = $clog2(POOL_SLOTS);
	localparam int LW  = $clog2(POOL_SLOTS + 1);
	localparam int PW  = (LW > POS_W) ? LW : POS_W;
	localparam int MW  = (SW > SLOT_W) ? SW : SLOT_W;
	localparam int LEW = (LW > LEN_W) ? LW : LEN_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_WALK = 6'b000100,
		S_WR1  = 6'b001000,
		S_WR2  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [SW-1:0] head_q, head_d, tail_q, tail_d;
	logic [LW-1:0] len_q, len_d, hw_q, hw_d;
	logic pend_q, pend_d;
	logic out_valid_q, out_valid_d;

	logic [OP_W-1:0] op_q, op_d;
	logic [VALUE_W-1:0] val_q, val_d;
	logic [POS_W-1:0] pos_q, pos_d, k_q, k_d;
	logic [SW-1:0] cur_q, cur_d, prev_q, prev_d, slot_q, slot_d, link_q, link_d;
	logic [SW-1:0] scan_s1, scan_d;
	logic [LW-1:0] iss_q, iss_d;
	status_t status_q, status_d;
	logic [VALUE_W-1:0] rv_q, rv_d;
	status_t out_status_q, out_status_d;
	logic [SLOT_W-1:0] out_slot_q, out_slot_d;
	logic [VALUE_W-1:0] out_rv_q, out_rv_d;
	logic [LEN_W-1:0] out_len_q, out_len_d;

	logic [SW-1:0] raddr;
	logic meta_we, val_we;
	logic [SW-1:0] meta_waddr, val_waddr;
	logic [SW:0] meta_wdata, meta_rdata;
	logic [VALUE_W-1:0] val_wdata, val_rdata;
	logic [MW-1:0] slot_wide;
	logic [LEW-1:0] len_wide;
	logic wr2_append_tail;

	assign slot_wide = MW'(slot_q);
	assign len_wide = LEW'(len_q);

	plle_ram #(.WIDTH(SW + 1), .DEPTH(POOL_SLOTS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (raddr),
		.rdata (meta_rdata)
	);

	plle_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_SLOTS)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (raddr),
		.rdata (val_rdata)
	);

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		len_d = len_q;
		hw_d = hw_q;
		pend_d = pend_q;
		out_valid_d = out_valid_q;
		op_d = op_q;
		val_d = val_q;
		pos_d = pos_q;
		k_d = k_q;
		cur_d = cur_q;
		prev_d = prev_q;
		slot_d = slot_q;
		link_d = link_q;
		scan_d = scan_s1;
		iss_d = iss_q;
		status_d = status_q;
		rv_d = rv_q;
		out_status_d = out_status_q;
		out_slot_d = out_slot_q;
		out_rv_d = out_rv_q;
		out_len_d = out_len_q;
		raddr = cur_q;
		meta_we = 1'b0;
		meta_waddr = slot_q;
		meta_wdata = '0;
		val_we = 1'b0;
		val_waddr = slot_q;
		val_wdata = val_q;

		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_d = s_tuser;
					val_d = s_tdata[VALUE_W-1:0];
					pos_d = s_tdata[VALUE_W+POS_W-1:VALUE_W];
					k_d = '0;
					pend_d = 1'b0;
					iss_d = '0;
					slot_d = '0;
					rv_d = '0;
					status_d = STAT_OK;
					cur_d = head_q;
					prev_d = head_q;
					case (s_tuser)
						OP_APPEND: begin
							state_d = S_SCAN;
						end
						OP_DELETE, OP_READ: begin
							if (PW'(s_tdata[VALUE_W+POS_W-1:VALUE_W]) >= PW'(len_q)) begin
								status_d = STAT_NOT_FOUND;
								state_d = S_DONE;
							end else begin
								state_d = S_WALK;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (pend_q && !meta_rdata[SW]) begin
					slot_d = scan_s1;
					pend_d = 1'b0;
					state_d = S_WR1;
				end else if (iss_q < hw_q) begin
					raddr = iss_q[SW-1:0];
					scan_d = iss_q[SW-1:0];
					iss_d = iss_q + 1'b1;
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (hw_q != LW'(POOL_SLOTS)) begin
						slot_d = hw_q[SW-1:0];
						hw_d = hw_q + 1'b1;
						state_d = S_WR1;
					end else begin
						status_d = STAT_FULL;
						state_d = S_DONE;
					end
				end
			end
			S_WALK: begin
				if (!pend_q) begin
					raddr = cur_q;
					pend_d = 1'b1;
				end else if (k_q == pos_q) begin
					pend_d = 1'b0;
					slot_d = cur_q;
					link_d = meta_rdata[SW-1:0];
					if (op_q == OP_READ) begin
						rv_d = val_rdata;
						state_d = S_DONE;
					end else begin
						state_d = S_WR1;
					end
				end else begin
					prev_d = cur_q;
					cur_d = meta_rdata[SW-1:0];
					raddr = meta_rdata[SW-1:0];
					k_d = k_q + 1'b1;
				end
			end
			S_WR1: begin
				val_we = 1'b1;
				meta_we = 1'b1;
				if (op_q == OP_APPEND) begin
					val_wdata = val_q;
					meta_wdata = {1'b1, {SW{1'b0}}};
					len_d = len_q + 1'b1;
					if (len_q == '0) begin
						head_d = slot_q;
						tail_d = slot_q;
						state_d = S_DONE;
					end else begin
						state_d = S_WR2;
					end
				end else begin
					val_wdata = '0;
					meta_wdata = '0;
					len_d = len_q - 1'b1;
					if (len_q == LW'(1)) begin
						head_d = '0;
						tail_d = '0;
						state_d = S_DONE;
					end else if (pos_q == '0) begin
						head_d = link_q;
						state_d = S_DONE;
					end else begin
						state_d = S_WR2;
					end
				end
			end
			S_WR2: begin
				meta_we = 1'b1;
				if (op_q == OP_APPEND) begin
					meta_waddr = tail_q;
					meta_wdata = {1'b1, slot_q};
					tail_d = slot_q;
				end else begin
					meta_waddr = prev_q;
					meta_wdata = {1'b1, link_q};
					if (slot_q == tail_q) begin
						tail_d = prev_q;
					end
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_valid_d = 1'b1;
					out_status_d = status_q;
					out_slot_d = slot_wide[SLOT_W-1:0];
					out_rv_d = rv_q;
					out_len_d = len_wide[LEN_W-1:0];
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			len_q <= '0;
			hw_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			len_q <= len_d;
			hw_q <= hw_d;
			pend_q <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		val_q <= val_d;
		pos_q <= pos_d;
		k_q <= k_d;
		cur_q <= cur_d;
		prev_q <= prev_d;
		slot_q <= slot_d;
		link_q <= link_d;
		scan_s1 <= scan_d;
		iss_q <= iss_d;
		status_q <= status_d;
		rv_q <= rv_d;
		out_status_q <= out_status_d;
		out_slot_q <= out_slot_d;
		out_rv_q <= out_rv_d;
		out_len_q <= out_len_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_len_q, out_rv_q, out_slot_q};
	assign m_tuser = out_status_q;

	assign wr2_append_tail = (state_q == S_WR2) && (op_q == OP_APPEND) && (tail_q == slot_q);

	`PLLE_ASSERT(a_len_within_hw, len_q <= hw_q, "list longer than slots ever used")
	`PLLE_ASSERT(a_hw_bound, hw_q <= LW'(POOL_SLOTS), "slot fill count beyond pool")
	`PLLE_ASSERT(a_walk_bound, (state_q == S_WALK) |-> (k_q <= pos_q), "walk passed position")
	`PLLE_NEVER(a_append_tail, wr2_append_tail, "append slot equals tail")
endmodule
